// ===== hdl/blg_pkg.sv =====
// Shared constants and helpers for the battery level gauge.
// Holds field widths, register indexes, reset values and the level saturator.
// No dependencies.
package blg_pkg;

    // Field and port widths
    localparam int LVL_W      = 18;
    localparam int RAW_W      = 16;
    localparam int TS_W       = 32;
    localparam int LED_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int S_DATA_W   = RAW_W + TS_W;
    localparam int M_DATA_W   = 2 * LVL_W + LED_W + 4;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SMP_INT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_INT  = 3'd7;

    // Register reset values
    localparam logic [15:0]        GAIN_RST      = 16'd8451;
    localparam logic signed [17:0] OFFSET_RST    = 18'sd10936;
    localparam logic [16:0]        FULL_RST      = 17'd50790;
    localparam logic [16:0]        EMPTY_RST     = 17'd45056;
    localparam logic [16:0]        MIN_VALID_RST = 17'd24576;
    localparam logic [10:0]        ALPHA_RST     = 11'd133;
    localparam logic [15:0]        SMP_INT_RST   = 16'd100;
    localparam logic [15:0]        ALERT_INT_RST = 16'd3000;

    // Level state reset (11.8 V) and limits
    localparam logic signed [LVL_W-1:0] LEVEL_RST = 18'sd48333;
    localparam logic [10:0]             ALPHA_ONE = 11'd1024;

    // Bar graph and blink timing
    localparam int BAR_STEPS       = 7;
    localparam int BLINK_PERIOD_MS = 400;
    localparam int BLK_W           = $clog2(BLINK_PERIOD_MS);

    // Saturate a wide signed value to the level range
    function automatic logic signed [LVL_W-1:0] sat_lvl(input logic signed [35:0] v);
        logic signed [35:0] lo;
        logic signed [35:0] hi;
        lo = -(36'sd1 <<< (LVL_W - 1));
        hi = (36'sd1 <<< (LVL_W - 1)) - 36'sd1;
        if (v < lo) begin
            sat_lvl = lo[LVL_W-1:0];
        end else if (v > hi) begin
            sat_lvl = hi[LVL_W-1:0];
        end else begin
            sat_lvl = v[LVL_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/battery_level_gauge_top.sv =====
// Battery level gauge: calibration, exponential filter, LED bar and alert pacing.
// Uses blg_pkg for widths, register indexes, reset values and saturation.
//
// Usage: ADC words enter on the s_ channel, one per handshake; s_tdata holds
// raw_sample (bits 15:0) and now_ms (bits 47:16), s_tuser holds sample_ok.
// A word arriving sooner than sample_interval_ms after the last word that passed
// this check is dropped with no result; the input reopens once that check is done.
// A taken word that passes runs the sequencer steps before m_tvalid rises, and a
// failed read skips the calibration and filter steps: 6 sequencer steps through one
// shared 19x17 multiplier (calibration, filter, bar numerator), 3 steps of the
// shared compare/subtract unit for the bar division and 2 for the blink phase
// (timestamp modulo the blink period by a reciprocal multiply). The block takes one
// word at a time; s_tready is high only while the sequencer idles.
// A finished result sits in the output register while the receiver stalls; the
// next word is still taken, and its result waits for that register to free.
// Configuration writes are applied at once and belong to idle periods.
// Reset (aresetn low, synchronous) loads the register defaults, sets both
// levels to 11.8 V, clears both timestamps and empties the output register.
module battery_level_gauge_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [blg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [blg_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Sample stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [blg_pkg::S_DATA_W-1:0]        s_tdata,   // raw_sample, now_ms
    input  logic                                s_tuser,   // sample_ok
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // filtered_voltage, instant_voltage, led_pattern, low_battery,
    // no_battery, normal_level, alert_start
    output logic [blg_pkg::M_DATA_W-1:0]        m_tdata
);
    import blg_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_CAL   = 4'd2;
    localparam logic [3:0] S_INST  = 4'd3;
    localparam logic [3:0] S_FILT  = 4'd4;
    localparam logic [3:0] S_FUPD  = 4'd5;
    localparam logic [3:0] S_FLAGS = 4'd6;
    localparam logic [3:0] S_NUM   = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_MOD   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_REM   = 4'd11;

    // Bar display modes
    localparam logic [1:0] BAR_FULL  = 2'd0;
    localparam logic [1:0] BAR_STEP  = 2'd1;
    localparam logic [1:0] BAR_BLINK = 2'd2;

    localparam int QW      = $clog2(BAR_STEPS + 1);
    localparam int SUB_W   = 22;
    localparam int STEP_W  = $clog2(QW + 1);
    localparam logic [STEP_W-1:0] DIV_FIRST = STEP_W'(QW - 1);
    localparam logic [BLK_W-1:0]  BLINK_HALF = BLK_W'(BLINK_PERIOD_MS / 2);

    // Reciprocal of the blink period, exact for every timestamp
    localparam int MAG_W     = TS_W + 1;
    localparam int MAG_SHIFT = TS_W + BLK_W;
    localparam logic [MAG_W-1:0] BLK_MAGIC =
        MAG_W'(((64'd1 << MAG_SHIFT) + 64'(BLINK_PERIOD_MS) - 64'd1) / 64'(BLINK_PERIOD_MS));

    // Configuration registers
    logic [15:0]        gain_reg;
    logic signed [17:0] offset_reg;
    logic [16:0]        full_reg;
    logic [16:0]        empty_reg;
    logic [16:0]        minv_reg;
    logic [10:0]        alpha_reg;
    logic [15:0]        smp_int_reg;
    logic [15:0]        alert_int_reg;

    // Block state
    logic [3:0]              state_reg;
    logic signed [LVL_W-1:0] filt_reg;
    logic signed [LVL_W-1:0] inst_reg;
    logic [TS_W-1:0]         last_upd_reg;
    logic [TS_W-1:0]         last_alert_reg;

    // Captured input word
    logic signed [RAW_W-1:0] raw_reg;
    logic                    ok_reg;
    logic [TS_W-1:0]         now_reg;

    // Working registers
    logic signed [35:0]  prod_reg;
    logic [SUB_W-1:0]    rem_reg;
    logic [QW-1:0]       q_reg;
    logic [BLK_W-1:0]    r_reg;
    logic [BLK_W-1:0]    blk_q_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [1:0]          bar_mode_reg;
    logic                low_reg;
    logic                none_reg;
    logic                normal_reg;
    logic                alert_reg;

    // Output register
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                out_load;

    // Shared multiplier operands
    logic signed [18:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [35:0] mul_p;

    // Shared compare/subtract unit
    logic [SUB_W-1:0] sub_x;
    logic [SUB_W-1:0] sub_y;
    logic [SUB_W:0]   sub_d;
    logic             sub_ge;

    // Blink period reciprocal product
    logic [TS_W+MAG_W-1:0] blk_prod;

    // Datapath helpers
    logic [10:0]        alpha_eff;
    logic signed [18:0] filt19;
    logic signed [18:0] empty19;
    logic signed [18:0] full19;
    logic signed [18:0] minv19;
    logic [16:0]        span;
    logic [TS_W-1:0]    upd_gap;
    logic [TS_W-1:0]    alert_gap;
    logic signed [35:0] cal_rnd;
    logic signed [35:0] cal_v;
    logic signed [35:0] flt_sum;
    logic signed [35:0] flt_rnd;
    logic [8:0]         bar_ones;
    logic [LED_W-1:0]   led_next;
    logic               f_low;
    logic               f_none;
    logic               f_normal;

    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign filt19    = {filt_reg[LVL_W-1], filt_reg};
    assign empty19   = {2'b00, empty_reg};
    assign full19    = {2'b00, full_reg};
    assign minv19    = {2'b00, minv_reg};
    assign span      = full_reg - empty_reg;
    assign upd_gap   = now_reg - last_upd_reg;
    assign alert_gap = now_reg - last_alert_reg;

    assign f_none   = filt19 < minv19;
    assign f_normal = filt19 >= empty19;
    assign f_low    = !f_normal && !f_none;

    // Calibration and filter rounding, half up
    assign cal_rnd = (prod_reg + 36'sd2048) >>> 12;
    assign cal_v   = cal_rnd + 36'(offset_reg);
    assign flt_sum = (36'(filt_reg) <<< 10) + prod_reg + 36'sd512;
    assign flt_rnd = flt_sum >>> 10;

    // Select multiplier operands by step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_CAL: begin
                mul_a = 19'(raw_reg);
                mul_b = {1'b0, gain_reg};
            end
            S_FILT: begin
                mul_a = {inst_reg[LVL_W-1], inst_reg} - filt19;
                mul_b = {6'b0, alpha_eff};
            end
            S_FLAGS: begin
                mul_a = filt19 - empty19;
                mul_b = 17'(2 * BAR_STEPS);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 36'(mul_a) * 36'(mul_b);

    // Quotient of the timestamp by the blink period, low bits kept
    assign blk_prod = {{MAG_W{1'b0}}, now_reg} * {{TS_W{1'b0}}, BLK_MAGIC};

    // Select compare/subtract operands for the bar division
    always_comb begin
        sub_x = '0;
        sub_y = '0;
        unique case (state_reg)
            S_DIV: begin
                sub_x = rem_reg;
                sub_y = SUB_W'(span) << (5'(step_reg) + 5'd1);
            end
            default: begin
                sub_x = '0;
                sub_y = '0;
            end
        endcase
    end

    assign sub_d  = {1'b0, sub_x} - {1'b0, sub_y};
    assign sub_ge = !sub_d[SUB_W];

    // Build the LED bar from the mode, quotient and blink phase
    assign bar_ones = (9'd1 << ({1'b0, q_reg} + 4'd1)) - 9'd1;
    always_comb begin
        case (bar_mode_reg)
            BAR_FULL:  led_next = 8'hFF;
            BAR_STEP:  led_next = bar_ones[LED_W-1:0];
            default:   led_next = (r_reg < BLINK_HALF) ? 8'h01 : 8'h00;
        endcase
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg      <= GAIN_RST;
            offset_reg    <= OFFSET_RST;
            full_reg      <= FULL_RST;
            empty_reg     <= EMPTY_RST;
            minv_reg      <= MIN_VALID_RST;
            alpha_reg     <= ALPHA_RST;
            smp_int_reg   <= SMP_INT_RST;
            alert_int_reg <= ALERT_INT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GAIN:      gain_reg      <= cfg_data[15:0];
                REG_OFFSET:    offset_reg    <= $signed(cfg_data[17:0]);
                REG_FULL:      full_reg      <= cfg_data[16:0];
                REG_EMPTY:     empty_reg     <= cfg_data[16:0];
                REG_MIN_VALID: minv_reg      <= cfg_data[16:0];
                REG_ALPHA:     alpha_reg     <= cfg_data[10:0];
                REG_SMP_INT:   smp_int_reg   <= cfg_data[15:0];
                REG_ALERT_INT: alert_int_reg <= cfg_data[15:0];
                default:       gain_reg      <= gain_reg;
            endcase
        end
    end

    // Product register runs every cycle
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
    end

    // Load the output register from the final step once it is free
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    // Sequencer and state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            filt_reg       <= LEVEL_RST;
            inst_reg       <= LEVEL_RST;
            last_upd_reg   <= '0;
            last_alert_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            // Raise on a new result, drop once the receiver takes it
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        raw_reg   <= $signed(s_tdata[RAW_W-1:0]);
                        now_reg   <= s_tdata[S_DATA_W-1:RAW_W];
                        ok_reg    <= s_tuser;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    // Drop words that come too soon
                    if (upd_gap < {16'b0, smp_int_reg}) begin
                        state_reg <= S_IDLE;
                    end else begin
                        last_upd_reg <= now_reg;
                        state_reg    <= ok_reg ? S_CAL : S_FLAGS;
                    end
                end
                S_CAL: begin
                    state_reg <= S_INST;
                end
                S_INST: begin
                    inst_reg  <= sat_lvl(cal_v);
                    state_reg <= S_FILT;
                end
                S_FILT: begin
                    state_reg <= S_FUPD;
                end
                S_FUPD: begin
                    filt_reg  <= sat_lvl(flt_rnd);
                    state_reg <= S_FLAGS;
                end
                S_FLAGS: begin
                    low_reg    <= f_low;
                    none_reg   <= f_none;
                    normal_reg <= f_normal;
                    if (f_low && alert_gap >= {16'b0, alert_int_reg}) begin
                        alert_reg      <= 1'b1;
                        last_alert_reg <= now_reg;
                    end else begin
                        alert_reg <= 1'b0;
                    end
                    if (filt19 >= full19) begin
                        bar_mode_reg <= BAR_FULL;
                    end else if (f_normal) begin
                        bar_mode_reg <= BAR_STEP;
                    end else begin
                        bar_mode_reg <= BAR_BLINK;
                    end
                    state_reg <= S_NUM;
                end
                S_NUM: begin
                    // Numerator 2*steps*(f - empty) + span, rounds half up
                    rem_reg   <= prod_reg[SUB_W-1:0] + SUB_W'(span);
                    q_reg     <= '0;
                    step_reg  <= DIV_FIRST;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (sub_ge) begin
                        rem_reg         <= sub_d[SUB_W-1:0];
                        q_reg[step_reg] <= 1'b1;
                    end
                    if (step_reg == '0) begin
                        state_reg <= S_MOD;
                    end else begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                S_MOD: begin
                    // Hold the low bits of the blink period quotient
                    blk_q_reg <= blk_prod[MAG_SHIFT +: BLK_W];
                    state_reg <= S_REM;
                end
                S_REM: begin
                    // Blink phase fits in the low bits of timestamp minus multiple
                    r_reg     <= now_reg[BLK_W-1:0] - blk_q_reg * BLK_W'(BLINK_PERIOD_MS);
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the output register is free
                    if (out_load) begin
                        m_tdata_reg <= {alert_reg, normal_reg, none_reg, low_reg,
                                        led_next, inst_reg, filt_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Exactly one level class per result
    a_flags_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tdata[M_DATA_W-2:M_DATA_W-4]))
        else $error("level flags not one-hot");

    // Alert pulses only on a low battery result
    a_alert_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[M_DATA_W-1]) |-> m_tdata[M_DATA_W-4])
        else $error("alert without low battery");

    // Taking a word closes the input until the sequencer returns
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input open right after accept");

    // A new result is only loaded from the final sequencer step
    a_load_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == S_OUT)
        else $error("result loaded outside output step");

endmodule

// ===== verif/battery_level_gauge_top_tb.sv =====
// Self-checking bench for battery_level_gauge_top: random sample words under shifting
// idle patterns, checked against a cycle-free prediction of the gauge.
// Depends on blg_pkg and the battery_level_gauge_top RTL only.
module battery_level_gauge_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import blg_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 64;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int PHASE_READINGS  = 168;
    localparam int NUM_PHASES      = 9;

    // Input word, lowest field last
    typedef struct packed {
        logic [TS_W-1:0]  now_ms;
        logic [RAW_W-1:0] raw_sample;
    } sample_word_t;

    // Result word, lowest field last
    typedef struct packed {
        logic                    alert_start;
        logic                    normal_level;
        logic                    no_battery;
        logic                    low_battery;
        logic [LED_W-1:0]        led_pattern;
        logic signed [LVL_W-1:0] instant_voltage;
        logic signed [LVL_W-1:0] filtered_voltage;
    } gauge_reading_t;

    // Mirrors the gauge registers and levels and keeps the readings still owed
    class gauge_scoreboard;
        logic [15:0]             gain;
        logic signed [17:0]      offset;
        logic [16:0]             full_lvl;
        logic [16:0]             empty_lvl;
        logic [16:0]             min_lvl;
        logic [10:0]             alpha;
        logic [15:0]             smp_int;
        logic [15:0]             alert_int;
        logic signed [LVL_W-1:0] filt_lvl;
        logic signed [LVL_W-1:0] inst_lvl;
        logic [TS_W-1:0]         last_update;
        logic [TS_W-1:0]         last_alert;
        gauge_reading_t          expected_readings[$];
        int                      errors;
        int                      checked;

        function new();
            gain        = GAIN_RST;
            offset      = OFFSET_RST;
            full_lvl    = FULL_RST;
            empty_lvl   = EMPTY_RST;
            min_lvl     = MIN_VALID_RST;
            alpha       = ALPHA_RST;
            smp_int     = SMP_INT_RST;
            alert_int   = ALERT_INT_RST;
            filt_lvl    = LEVEL_RST;
            inst_lvl    = LEVEL_RST;
            last_update = '0;
            last_alert  = '0;
            errors      = 0;
            checked     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GAIN:      gain      = data[15:0];
                REG_OFFSET:    offset    = data;
                REG_FULL:      full_lvl  = data[16:0];
                REG_EMPTY:     empty_lvl = data[16:0];
                REG_MIN_VALID: min_lvl   = data[16:0];
                REG_ALPHA:     alpha     = data[10:0];
                REG_SMP_INT:   smp_int   = data[15:0];
                REG_ALERT_INT: alert_int = data[15:0];
                default: ;
            endcase
        endfunction

        function longint clamp_level(longint x);
            if (x < -131072) return -131072;
            if (x > 131071) return 131071;
            return x;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        // Advance the gauge by one taken word; returns 1 if a reading is owed
        function bit note_sample(logic [RAW_W-1:0] raw, logic ok, logic [TS_W-1:0] now);
            gauge_reading_t  want;
            longint          prod, volts, wgt, mix, fl, full_v, empty_v, min_v, span, steps;
            logic [TS_W-1:0] since;
            since = now - last_update;
            if (since < {16'd0, smp_int}) return 1'b0;
            last_update = now;

            // Calibrate and filter; a failed read keeps both levels
            if (ok) begin
                prod     = longint'($signed(raw)) * longint'(gain);
                volts    = ((prod + 2048) >>> 12) + longint'(offset);
                inst_lvl = LVL_W'(clamp_level(volts));
                wgt      = (alpha > ALPHA_ONE) ? 1024 : longint'(alpha);
                mix      = (1024 - wgt) * longint'(filt_lvl) + wgt * longint'(inst_lvl);
                filt_lvl = LVL_W'(clamp_level((mix + 512) >>> 10));
            end

            fl      = longint'(filt_lvl);
            full_v  = longint'(full_lvl);
            empty_v = longint'(empty_lvl);
            min_v   = longint'(min_lvl);
            want.filtered_voltage = filt_lvl;
            want.instant_voltage  = inst_lvl;
            want.low_battery      = (fl < empty_v) && (fl >= min_v);
            want.no_battery       = (fl < min_v);
            want.normal_level     = (fl >= empty_v);

            // Pace the alert on wrapping time
            want.alert_start = 1'b0;
            since = now - last_alert;
            if (want.low_battery && since >= {16'd0, alert_int}) begin
                last_alert       = now;
                want.alert_start = 1'b1;
            end

            // Bar: full, stepped, or a single blinking LED
            if (fl >= full_v) begin
                want.led_pattern = 8'hFF;
            end else if (fl >= empty_v) begin
                span  = full_v - empty_v;
                steps = ((fl - empty_v) * 2 * BAR_STEPS + span) / (2 * span);
                if (steps < 0) steps = 0;
                if (steps > 7) steps = 7;
                want.led_pattern = LED_W'((longint'(1) << (steps + 1)) - 1);
            end else begin
                want.led_pattern = ((now % BLINK_PERIOD_MS) >= (BLINK_PERIOD_MS / 2)) ?
                                   8'h00 : 8'h01;
            end

            expected_readings.push_back(want);
            return 1'b1;
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40) $display("reading %0d: %s", checked, msg);
        endtask

        task check_reading(gauge_reading_t got);
            gauge_reading_t want;
            checked++;
            if (expected_readings.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", got));
                return;
            end
            want = expected_readings.pop_front();
            if (got.filtered_voltage !== want.filtered_voltage)
                report_mismatch($sformatf("filtered_voltage %0d, want %0d",
                                          got.filtered_voltage, want.filtered_voltage));
            if (got.instant_voltage !== want.instant_voltage)
                report_mismatch($sformatf("instant_voltage %0d, want %0d",
                                          got.instant_voltage, want.instant_voltage));
            if (got.led_pattern !== want.led_pattern)
                report_mismatch($sformatf("led_pattern %h, want %h",
                                          got.led_pattern, want.led_pattern));
            if (got.low_battery !== want.low_battery)
                report_mismatch($sformatf("low_battery %b, want %b",
                                          got.low_battery, want.low_battery));
            if (got.no_battery !== want.no_battery)
                report_mismatch($sformatf("no_battery %b, want %b",
                                          got.no_battery, want.no_battery));
            if (got.normal_level !== want.normal_level)
                report_mismatch($sformatf("normal_level %b, want %b",
                                          got.normal_level, want.normal_level));
            if (got.alert_start !== want.alert_start)
                report_mismatch($sformatf("alert_start %b, want %b",
                                          got.alert_start, want.alert_start));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;

    int                    send_idle_pct;
    int                    recv_stall_pct;
    int                    hold_off_req;
    logic [CFG_DATA_W-1:0] setting [8];
    gauge_scoreboard       sb = new();

    battery_level_gauge_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Result side: check each word, stall at random, hold off on request
    initial begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_reading(m_tdata);
            if (hold_off_req != hold_seen) begin
                hold_seen = hold_off_req;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
            end
        end
    end

    // End the run when no word moves on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("battery_level_gauge_top_tb NOT OK");
        $finish;
    end

    // Offer one word after an optional gap with tvalid low; with no gap tvalid stays high
    task automatic send_sample(input logic [RAW_W-1:0] raw, input logic ok,
                               input logic [TS_W-1:0] now, output bit owed);
        sample_word_t word;
        if ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99, 0) < send_idle_pct);
        end
        word.raw_sample = raw;
        word.now_ms     = now;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= ok;
        do @(posedge aclk); while (!s_tready);
        owed = sb.note_sample(raw, ok, now);
    endtask

    // Drop tvalid, wait for all owed readings, then let in-flight drops finish
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_settings();
        int i;
        for (i = 0; i < 8; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= setting[i];
            @(posedge aclk);
            sb.set_reg(CFG_IDX_W'(i), setting[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Extremes first, then the equal-threshold case, then random operating points
    task automatic pick_settings(input int k);
        int ofs;
        int empty_v;
        case (k)
            1: begin
                setting[REG_GAIN]      = 18'd65535;
                setting[REG_OFFSET]    = 18'h20000;
                setting[REG_FULL]      = 18'd131071;
                setting[REG_EMPTY]     = 18'd0;
                setting[REG_MIN_VALID] = 18'd0;
                setting[REG_ALPHA]     = 18'd1024;
                setting[REG_SMP_INT]   = 18'd0;
                setting[REG_ALERT_INT] = 18'd0;
            end
            2: begin
                setting[REG_GAIN]      = 18'd0;
                setting[REG_OFFSET]    = 18'h1FFFF;
                setting[REG_FULL]      = 18'd0;
                setting[REG_EMPTY]     = 18'd131071;
                setting[REG_MIN_VALID] = 18'd131071;
                setting[REG_ALPHA]     = 18'd0;
                setting[REG_SMP_INT]   = 18'd65535;
                setting[REG_ALERT_INT] = 18'd65535;
            end
            3: begin
                setting[REG_GAIN]      = 18'(GAIN_RST);
                setting[REG_OFFSET]    = OFFSET_RST;
                setting[REG_FULL]      = 18'd45056;
                setting[REG_EMPTY]     = 18'd45056;
                setting[REG_MIN_VALID] = 18'd24576;
                setting[REG_ALPHA]     = 18'd2047;
                setting[REG_SMP_INT]   = 18'd1;
                setting[REG_ALERT_INT] = 18'd1;
            end
            default: begin
                ofs     = int'($urandom_range(0, 40000)) - 20000;
                empty_v = int'($urandom_range(30000, 70000));
                setting[REG_GAIN]   = 18'($urandom_range(4000, 16000));
                setting[REG_OFFSET] = 18'(ofs);
                setting[REG_EMPTY]  = 18'(empty_v);
                if ($urandom_range(9, 0) == 0) begin
                    setting[REG_FULL] = 18'($urandom_range(0, empty_v));
                end else begin
                    setting[REG_FULL] = 18'(empty_v + int'($urandom_range(1, 30000)));
                end
                setting[REG_MIN_VALID] = 18'($urandom_range(10000, empty_v));
                if ($urandom_range(9, 0) == 0) begin
                    setting[REG_ALPHA] = 18'($urandom_range(1025, 2047));
                end else begin
                    setting[REG_ALPHA] = 18'($urandom_range(0, 1024));
                end
                setting[REG_SMP_INT]   = 18'($urandom_range(1, 300));
                setting[REG_ALERT_INT] = 18'($urandom_range(1, 4000));
            end
        endcase
    endtask

    // Edge samples, failed reads, a slide through the low band, timestamp wrap
    task automatic run_directed();
        bit              owed;
        int              i;
        logic [TS_W-1:0] t;
        send_sample(16'd20000, 1'b1, 32'd50, owed);
        send_sample(16'd20000, 1'b1, 32'd100, owed);
        send_sample(16'd20000, 1'b1, 32'd150, owed);
        send_sample(16'd0, 1'b0, 32'd250, owed);
        send_sample(16'h7FFF, 1'b1, 32'd400, owed);
        send_sample(16'h8000, 1'b1, 32'd700, owed);
        send_sample(16'd0, 1'b1, 32'd1000, owed);
        send_sample(16'hFFFF, 1'b1, 32'd1300, owed);
        t = 32'd1610;
        for (i = 0; i < 12; i++) begin
            send_sample(16'd0, 1'b1, t, owed);
            t = t + 32'd310;
        end
        send_sample(16'd22000, 1'b1, 32'hFFFF_FF9C, owed);
        send_sample(16'd22000, 1'b1, 32'h0000_0000, owed);
        send_sample(16'h5A5A, 1'b1, 32'h5555_AAAA, owed);
        send_sample(16'hA5A5, 1'b0, 32'hAAAA_5555, owed);
    endtask

    // Mostly well-spaced samples near the working range, with early words,
    // random jumps and timestamps close to the wrap mixed in
    task automatic run_phase(input int n_readings);
        int              got;
        int              pick;
        bit              owed;
        logic [RAW_W-1:0] raw;
        logic            ok;
        logic [TS_W-1:0] now;
        got = 0;
        while (got < n_readings) begin
            pick = $urandom_range(99, 0);
            if (pick < 78) begin
                now = sb.last_update + sb.smp_int + $urandom_range(0, 400);
            end else if (pick < 88) begin
                now = sb.last_update + $urandom_range(0, sb.smp_int);
            end else if (pick < 96) begin
                now = $urandom();
            end else begin
                now = 32'hFFFF_FFFF - $urandom_range(0, 300);
            end
            pick = $urandom_range(99, 0);
            if (pick < 60) begin
                raw = RAW_W'($urandom_range(12000, 26000));
            end else if (pick < 85) begin
                raw = RAW_W'($urandom());
            end else begin
                case ($urandom_range(3, 0))
                    0:       raw = 16'h7FFF;
                    1:       raw = 16'h8000;
                    2:       raw = 16'h0000;
                    default: raw = 16'hFFFF;
                endcase
            end
            ok = ($urandom_range(99, 0) < 90);
            send_sample(raw, ok, now, owed);
            if (owed) got++;
        end
    endtask

    initial begin : stimulus
        int k;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_phase(PHASE_READINGS);

        for (k = 1; k < NUM_PHASES; k++) begin
            settle_idle();
            pick_settings(k);
            load_settings();
            // Rotate idle pattern: none, sender, receiver, both
            case (k % 4)
                1: begin
                    send_idle_pct   = 69;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 69;
                end
                3: begin
                    send_idle_pct   = 38;
                    recv_stall_pct <= 38;
                end
                default: begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 0;
                end
            endcase
            // Back up the result side while words keep coming
            if (k == 4) hold_off_req <= hold_off_req + 1;
            run_phase(PHASE_READINGS);
        end

        settle_idle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("battery_level_gauge_top_tb OK");
        end else begin
            $display("battery_level_gauge_top_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/blg_pkg.sv
hdl/battery_level_gauge_top.sv
verif/battery_level_gauge_top_tb.sv
